// File: rtl/core/smpf_pkg.sv
package smpf_pkg;

   localparam int NUMBER_WIDTH = 32;
   localparam int MAX_RESULTS  = 10;

   // Trial divisors never pass the square root of the number, plus one step.
   localparam int DIV_WIDTH    = (NUMBER_WIDTH + 1) / 2 + 1;
   localparam int COUNT_WIDTH  = $clog2(MAX_RESULTS + 1);
   localparam int STEP_WIDTH   = $clog2(NUMBER_WIDTH);

   typedef logic [NUMBER_WIDTH-1:0] number_type;
   typedef logic [DIV_WIDTH-1:0]    divisor_type;

   typedef struct packed {
      number_type  quotient;
      divisor_type remainder;
   } div_result_type;

endpackage

// File: rtl/core/smpf_divider.sv
module smpf_divider
   import smpf_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           div_start,
   input  number_type     div_dividend,
   input  divisor_type    div_divisor,
   output logic           div_done,
   output div_result_type div_result
);

   logic        run_ff, run_in;
   logic        done_ff, done_in;
   logic [STEP_WIDTH-1:0] step_ff, step_in;
   number_type  quo_ff, quo_in;
   divisor_type part_ff, part_in;
   divisor_type den_ff, den_in;

   logic [DIV_WIDTH:0] shifted;
   logic [DIV_WIDTH:0] diff;
   logic               fits;

   always_comb begin
      shifted = {part_ff, quo_ff[NUMBER_WIDTH-1]};
      diff    = shifted - {1'b0, den_ff};
      fits    = (shifted >= {1'b0, den_ff});

      run_in  = run_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in  = quo_ff;
      part_in = part_ff;
      den_in  = den_ff;

      if (div_start) begin
         run_in  = 1'b1;
         step_in = STEP_WIDTH'(NUMBER_WIDTH - 1);
         quo_in  = div_dividend;
         part_in = '0;
         den_in  = div_divisor;
      end else if (run_ff) begin
         quo_in  = {quo_ff[NUMBER_WIDTH-2:0], fits};
         part_in = fits ? diff[DIV_WIDTH-1:0] : shifted[DIV_WIDTH-1:0];
         step_in = step_ff - 1'b1;
         if (step_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      quo_ff  <= quo_in;
      part_ff <= part_in;
      den_ff  <= den_in;
   end

   assign div_done             = done_ff;
   assign div_result.quotient  = quo_ff;
   assign div_result.remainder = part_ff;

endmodule

// File: rtl/core/single_multiplicity_prime_factors.sv
// Each candidate divisor takes one trial division, plus one per repeated factor; a tail
// state and a flush state then close the transaction. Throughput is one transaction at
// a time. The bit-serial divider computes one quotient bit per cycle.
// Results are one-cycle strobes and the receiver cannot stall them.
// Synchronous active-high reset returns the block to idle with no result pending.
module single_multiplicity_prime_factors
   import smpf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  number_type req_number,
   output logic       rsp_valid,
   output number_type rsp_factor,
   output logic       rsp_found,
   output logic       rsp_last
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_ISSUE = 3'd1;
   localparam logic [2:0] ST_DIV   = 3'd2;
   localparam logic [2:0] ST_TAIL  = 3'd3;
   localparam logic [2:0] ST_FLUSH = 3'd4;

   localparam logic [1:0] TIMES_NONE = 2'd0;
   localparam logic [1:0] TIMES_ONE  = 2'd1;
   localparam logic [1:0] TIMES_MANY = 2'd2;

   logic [2:0]  state_ff, state_in;
   number_type  rem_ff, rem_in;
   divisor_type d_ff, d_in;
   logic [1:0]  times_ff, times_in;
   logic        outer_ff, outer_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic        pend_valid_ff, pend_valid_in;
   number_type  pend_ff, pend_in;
   logic        rsp_valid_ff, rsp_valid_in;
   number_type  rsp_factor_ff, rsp_factor_in;
   logic        rsp_found_ff, rsp_found_in;
   logic        rsp_last_ff, rsp_last_in;

   logic           div_start;
   logic           div_done;
   div_result_type div_result;
   number_type     d_wide;
   logic           push;
   number_type     push_value;

   smpf_divider u_divider (
      .clock        (clock),
      .reset        (reset),
      .div_start    (div_start),
      .div_dividend (rem_ff),
      .div_divisor  (d_ff),
      .div_done     (div_done),
      .div_result   (div_result)
   );

   assign div_start = (state_ff == ST_ISSUE);
   assign d_wide    = {{(NUMBER_WIDTH - DIV_WIDTH){1'b0}}, d_ff};

   always_comb begin
      state_in      = state_ff;
      rem_in        = rem_ff;
      d_in          = d_ff;
      times_in      = times_ff;
      outer_in      = outer_ff;
      count_in      = count_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = 1'b0;
      rsp_factor_in = rsp_factor_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_last_in   = rsp_last_ff;
      push          = 1'b0;
      push_value    = d_wide;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               rem_in        = req_number;
               d_in          = DIV_WIDTH'(2);
               times_in      = TIMES_NONE;
               outer_in      = 1'b1;
               count_in      = '0;
               pend_valid_in = 1'b0;
               state_in      = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               if (outer_ff && (d_wide > div_result.quotient)) begin
                  state_in = ST_TAIL;
               end else if (div_result.remainder == '0) begin
                  rem_in   = div_result.quotient;
                  times_in = (times_ff == TIMES_NONE) ? TIMES_ONE : TIMES_MANY;
                  outer_in = 1'b0;
                  state_in = ST_ISSUE;
               end else begin
                  push     = (times_ff == TIMES_ONE);
                  times_in = TIMES_NONE;
                  d_in     = d_ff + 1'b1;
                  outer_in = 1'b1;
                  state_in = ST_ISSUE;
               end
            end
         end
         ST_TAIL: begin
            push       = (rem_ff > NUMBER_WIDTH'(1));
            push_value = rem_ff;
            state_in   = ST_FLUSH;
         end
         ST_FLUSH: begin
            rsp_valid_in  = 1'b1;
            rsp_factor_in = pend_valid_ff ? pend_ff : '0;
            rsp_found_in  = pend_valid_ff;
            rsp_last_in   = 1'b1;
            pend_valid_in = 1'b0;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // A factor is held back one step so that the final one can carry the last flag.
      if (push && (count_ff < COUNT_WIDTH'(MAX_RESULTS))) begin
         if (pend_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_factor_in = pend_ff;
            rsp_found_in  = 1'b1;
            rsp_last_in   = 1'b0;
         end
         pend_in       = push_value;
         pend_valid_in = 1'b1;
         count_in      = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         count_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         count_ff      <= count_in;
      end
      rem_ff        <= rem_in;
      d_ff          <= d_in;
      times_ff      <= times_in;
      outer_ff      <= outer_in;
      pend_ff       <= pend_in;
      rsp_factor_ff <= rsp_factor_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_factor = rsp_factor_ff;
   assign rsp_found  = rsp_found_ff;
   assign rsp_last   = rsp_last_ff;

`ifndef SYNTHESIS
   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> (rsp_last && (rsp_factor == '0)))
      else $error("empty transaction result is not final or carries a factor");

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV))
      else $error("divider finished outside the wait state");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not raise busy");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> !busy)
      else $error("final result issued while the transaction is still running");
`endif

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top
   import smpf_pkg::*;
();

   localparam int CLOCK_PERIOD  = 8;
   localparam int RESET_CYCLES  = 4;
   localparam int MAX_GAP       = 10;
   localparam int RANDOM_ITEMS  = 100;
   localparam int DRAIN_CYCLES  = 200;
   localparam int CYCLE_LIMIT   = 6_000_000;

   typedef struct {
      number_type factor;
      logic       found;
      logic       last;
   } factor_result_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   number_type req_number = '0;
   logic       busy;
   logic       rsp_valid;
   number_type rsp_factor;
   logic       rsp_found;
   logic       rsp_last;

   number_type        numbers_to_send[$];
   factor_result_type factors_expected[$];
   int                gap_left = 0;
   int                error_count = 0;
   int unsigned       cycle_count = 0;

   single_multiplicity_prime_factors u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_number (req_number),
      .rsp_valid  (rsp_valid),
      .rsp_factor (rsp_factor),
      .rsp_found  (rsp_found),
      .rsp_last   (rsp_last)
   );

   initial begin
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // Works out the primes of multiplicity one of a number, in ascending order.
   function automatic void predict_unique_factors(number_type number);
      bit [63:0]         rem;
      bit [63:0]         divisor;
      int unsigned       times;
      number_type        primes[$];
      factor_result_type item;
      rem = number;
      divisor = 2;
      while (divisor <= rem / divisor) begin
         times = 0;
         while (rem % divisor == 0) begin
            rem = rem / divisor;
            times++;
         end
         if (times == 1 && primes.size() < MAX_RESULTS) primes.push_back(divisor[31:0]);
         divisor++;
      end
      if (rem > 1 && primes.size() < MAX_RESULTS) primes.push_back(rem[31:0]);
      if (primes.size() == 0) begin
         item.factor = '0;
         item.found  = 1'b0;
         item.last   = 1'b1;
         factors_expected.push_back(item);
      end else begin
         foreach (primes[i]) begin
            item.factor = primes[i];
            item.found  = 1'b1;
            item.last   = (i == primes.size() - 1);
            factors_expected.push_back(item);
         end
      end
   endfunction

   // Smooth numbers keep trial division short: small factors, at most one up to 16 bits.
   function automatic number_type draw_number();
      bit [63:0]   product;
      int unsigned base;
      int unsigned kind;
      kind = $urandom_range(0, 9);
      if (kind == 0) return $urandom_range(0, 65535);
      product = 1;
      if (kind < 5) product = $urandom_range(2, 65535);
      repeat ($urandom_range(1, 12)) begin
         base = $urandom_range(2, 127);
         if ($urandom_range(0, 3) == 0) base = base * base;
         if (product * base <= 64'hFFFF_FFFF) product = product * base;
      end
      return product[31:0];
   endfunction

   always @(posedge clock) begin
      int next_gap;
      if (reset) begin
         start    <= 1'b0;
         gap_left <= $urandom_range(0, MAX_GAP);
      end else if (start) begin
         if (!busy) begin
            predict_unique_factors(req_number);
            next_gap = $urandom_range(0, MAX_GAP);
            gap_left <= next_gap;
            if (next_gap == 0 && numbers_to_send.size() > 0) begin
               req_number <= numbers_to_send.pop_front();
            end else begin
               start <= 1'b0;
            end
         end
      end else if (gap_left > 0) begin
         gap_left <= gap_left - 1;
      end else if (numbers_to_send.size() > 0) begin
         req_number <= numbers_to_send.pop_front();
         start      <= 1'b1;
      end
   end

   always @(posedge clock) begin
      factor_result_type want;
      if (!reset && rsp_valid) begin
         if (factors_expected.size() == 0) begin
            $display("%0t: unexpected transaction factor %0d found %0b last %0b",
                     $time, rsp_factor, rsp_found, rsp_last);
            error_count++;
         end else begin
            want = factors_expected.pop_front();
            if (rsp_factor !== want.factor) begin
               $display("%0t: factor expected %0d actual %0d", $time, want.factor, rsp_factor);
               error_count++;
            end
            if (rsp_found !== want.found) begin
               $display("%0t: found expected %0b actual %0b", $time, want.found, rsp_found);
               error_count++;
            end
            if (rsp_last !== want.last) begin
               $display("%0t: last expected %0b actual %0b", $time, want.last, rsp_last);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      number_type directed[$];
      directed = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd6, 32'd12, 32'd30, 32'd36,
                   32'd147, 32'd8633, 32'd65521, 32'd65536, 32'd65537,
                   32'd223092870, 32'd281291010, 32'h8000_0000, 32'hFFFF_FFFF,
                   32'hFFFE_0001, 32'hFFFF_0000, 32'hAAAA_AAAA, 32'h5555_5555};
      foreach (directed[i]) numbers_to_send.push_back(directed[i]);
      repeat (RANDOM_ITEMS) numbers_to_send.push_back(draw_number());

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      while (numbers_to_send.size() > 0 || start) @(posedge clock);
      while (factors_expected.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
